### rtl/lfo_pkg.sv
// Shared constants, register and shape codes, and lookup functions for the
// multi-shape LFO with fade-in. No dependencies.
`default_nettype none

package lfo_pkg;

  // Default sizes handed to the top level
  localparam int unsigned PHASE_BITS_DEF = 32;
  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned LEVEL_BITS_DEF = 24;

  // Fixed field widths
  localparam int unsigned START_W = 32;
  localparam int unsigned STEP_W  = 32;
  localparam int unsigned RATE_W  = 25;
  localparam int unsigned SHAPE_W = 3;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned CDATA_W = 32;
  localparam int unsigned MUL_W   = 32;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_SHAPE = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_STEP  = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_RATE  = 2'd2;

  // Shape codes
  localparam logic [SHAPE_W-1:0] SHAPE_SINE   = 3'd0;
  localparam logic [SHAPE_W-1:0] SHAPE_TRI    = 3'd1;
  localparam logic [SHAPE_W-1:0] SHAPE_SAW    = 3'd2;
  localparam logic [SHAPE_W-1:0] SHAPE_SQUARE = 3'd3;
  localparam logic [SHAPE_W-1:0] SHAPE_STEP   = 3'd4;

  // Request kinds
  localparam logic REQ_ADVANCE = 1'b0;
  localparam logic REQ_RETRIG  = 1'b1;

  localparam logic [RATE_W-1:0] FADE_ONE = 25'h100_0000;

  // Q2.30 landmarks, 32 and 33 bits wide
  localparam logic [31:0] Q30_ONE = 32'h4000_0000;
  localparam logic [32:0] QX_ONE   = 33'h0_4000_0000;
  localparam logic [32:0] QX_TWO   = 33'h0_8000_0000;
  localparam logic [32:0] QX_THREE = 33'h0_C000_0000;
  localparam logic [32:0] QX_FOUR  = 33'h1_0000_0000;

  // Odd Taylor coefficients of sin(pi*x/2), Q2.30 magnitudes
  localparam logic [31:0] SC1  = 32'd1686629713;
  localparam logic [31:0] SC3  = 32'd693598668;
  localparam logic [31:0] SC5  = 32'd85569306;
  localparam logic [31:0] SC7  = 32'd5026995;
  localparam logic [31:0] SC9  = 32'd172272;
  localparam logic [31:0] SC11 = 32'd3864;

  localparam logic [2:0] HORNER_LAST = 3'd4;

  // Horner step k uses SC9, SC7, SC5, SC3, SC1 in turn
  function automatic logic [31:0] sin_coef(input logic [2:0] k);
    logic [31:0] c;
    unique case (k)
      3'd0:    c = SC9;
      3'd1:    c = SC7;
      3'd2:    c = SC5;
      3'd3:    c = SC3;
      3'd4:    c = SC1;
      default: c = '0;
    endcase
    return c;
  endfunction

  // sin(k*7.3), magnitude in Q2.30
  function automatic logic [31:0] step_mag(input logic [2:0] k);
    logic [31:0] m;
    unique case (k)
      3'd0:    m = 32'd0;
      3'd1:    m = 32'd913149824;
      3'd2:    m = 32'd960774528;
      3'd3:    m = 32'd97735168;
      3'd4:    m = 32'd857942272;
      3'd5:    m = 32'd1000423552;
      3'd6:    m = 32'd194657536;
      default: m = 32'd795613696;
    endcase
    return m;
  endfunction

  function automatic logic step_neg(input logic [2:0] k);
    return (k == 3'd4) || (k == 3'd5) || (k == 3'd6);
  endfunction

endpackage

`default_nettype wire

### rtl/lfo_multi_shape_with_fade.sv
// Multi-shape LFO with fade-in: phase accumulator, five shapes, fade gain.
// All products go through one shared 32x32 multiplier. Depends on lfo_pkg.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------------------
//  s_axis   | in        | s_axis_tvalid/tready   | tdata: count, start; tuser: kind
//  m_axis   | out       | m_axis_tvalid/tready   | tdata: level
//  cfg      | in        | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// A zero-count advance goes straight to ST_DONE; the other transactions step through
// the single multiplier with its registered product, the sine longest (squaring, five
// Horner steps, final scaling). s_axis_tready is high only
// in idle; the next transaction is taken while a result waits on m_axis, and its
// level is held in ST_DONE until the output register is free.
// Reset clears phase, fade, held level and the configuration registers.
`default_nettype none

module lfo_multi_shape_with_fade #(
  parameter int unsigned PHASE_BITS = lfo_pkg::PHASE_BITS_DEF,
  parameter int unsigned COUNT_BITS = lfo_pkg::COUNT_BITS_DEF,
  parameter int unsigned LEVEL_BITS = lfo_pkg::LEVEL_BITS_DEF,
  localparam int unsigned IN_W  = ((COUNT_BITS + lfo_pkg::START_W + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((LEVEL_BITS + 7) / 8) * 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [IN_W-1:0]             s_axis_tdata,  // sample_count, start_phase
  input  wire logic                        s_axis_tuser,  // req_type
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [OUT_W-1:0]                 m_axis_tdata,  // level
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [lfo_pkg::CIDX_W-1:0]  cfg_index_i,
  input  wire logic [lfo_pkg::CDATA_W-1:0] cfg_data_i
);

  localparam int unsigned RND_SH = 55 - LEVEL_BITS;
  localparam logic [63:0] RND_HALF = 64'd1 << (RND_SH - 1);
  localparam logic [63:0] NEG_MAX  = 64'd1 << (LEVEL_BITS - 1);
  localparam logic [63:0] POS_MAX  = NEG_MAX - 64'd1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PH_MUL, ST_PH_ADD, ST_FD_MUL, ST_FD_ADD, ST_SHAPE, ST_SQ,
    ST_SIN_Y, ST_HORN_MUL, ST_HORN_SUB, ST_SIN_M, ST_SIN_MAG, ST_FADE_MUL,
    ST_ROUND, ST_DONE
  } state_e;

  state_e                        state_q;
  logic [PHASE_BITS-1:0]         phase_q;
  logic [lfo_pkg::RATE_W-1:0]    fade_q;
  logic [LEVEL_BITS-1:0]         level_q;
  logic [LEVEL_BITS-1:0]         out_level_q;
  logic                          out_valid_q;
  logic [lfo_pkg::SHAPE_W-1:0]   shape_q;
  logic [lfo_pkg::STEP_W-1:0]    step_q;
  logic [lfo_pkg::RATE_W-1:0]    rate_q;
  logic [COUNT_BITS-1:0]         count_q;
  logic [30:0]                   m_q;
  logic [31:0]                   y_q;
  logic [31:0]                   p_q;
  logic [31:0]                   mag_q;
  logic                          neg_q;
  logic [2:0]                    k_q;
  logic [63:0]                   mul_p_q;

  logic [lfo_pkg::MUL_W-1:0]     mul_a;
  logic [lfo_pkg::MUL_W-1:0]     mul_b;
  logic [lfo_pkg::RATE_W-1:0]    fade_eff;
  logic                          fade_on;
  logic                          out_load;

  logic [COUNT_BITS-1:0]         in_count;
  logic [lfo_pkg::START_W-1:0]   in_start;

  logic [PHASE_BITS+31:0]        ph_ext;
  logic [31:0]                   ph_frac;
  logic [32:0]                   fx;
  logic [30:0]                   fold_d;
  logic                          fold_neg_d;
  logic [31:0]                   dist_d;
  logic [31:0]                   shp_mag_d;
  logic                          shp_neg_d;

  logic [25:0]                   fade_sum_d;
  logic [lfo_pkg::RATE_W-1:0]    fade_d;
  logic [63:0]                   rnd_d;
  logic [63:0]                   lim_d;
  logic [LEVEL_BITS-1:0]         level_d;

  assign in_count = s_axis_tdata[COUNT_BITS-1:0];
  assign in_start = s_axis_tdata[COUNT_BITS+lfo_pkg::START_W-1:COUNT_BITS];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'(out_level_q);

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

  assign fade_on  = (rate_q != '0);
  assign fade_eff = fade_on ? fade_q : lfo_pkg::FADE_ONE;

  // Phase as a 32-bit fraction of a cycle
  assign ph_ext  = {phase_q, 32'd0} >> PHASE_BITS;
  assign ph_frac = ph_ext[31:0];
  assign fx      = {1'b0, ph_frac};

  always_comb begin
    fold_d     = '0;
    fold_neg_d = 1'b0;
    if (fx < lfo_pkg::QX_ONE) begin
      fold_d = fx[30:0];
    end else if (fx < lfo_pkg::QX_THREE) begin
      if (fx <= lfo_pkg::QX_TWO) begin
        fold_d = 31'(lfo_pkg::QX_TWO - fx);
      end else begin
        fold_d     = 31'(fx - lfo_pkg::QX_TWO);
        fold_neg_d = 1'b1;
      end
    end else begin
      fold_d     = 31'(lfo_pkg::QX_FOUR - fx);
      fold_neg_d = 1'b1;
    end
  end

  always_comb begin
    dist_d    = '0;
    shp_mag_d = '0;
    shp_neg_d = 1'b0;
    unique case (shape_q)
      lfo_pkg::SHAPE_SINE: begin
        shp_neg_d = fold_neg_d;
      end
      lfo_pkg::SHAPE_TRI: begin
        dist_d = ph_frac[31] ? {1'b0, ph_frac[30:0]} : 32'(lfo_pkg::QX_TWO - fx);
        if (dist_d <= lfo_pkg::Q30_ONE) begin
          shp_mag_d = lfo_pkg::Q30_ONE - dist_d;
        end else begin
          shp_mag_d = dist_d - lfo_pkg::Q30_ONE;
          shp_neg_d = 1'b1;
        end
      end
      lfo_pkg::SHAPE_SAW: begin
        dist_d = {1'b0, ph_frac[31:1]};
        if (dist_d <= lfo_pkg::Q30_ONE) begin
          shp_mag_d = lfo_pkg::Q30_ONE - dist_d;
        end else begin
          shp_mag_d = dist_d - lfo_pkg::Q30_ONE;
          shp_neg_d = 1'b1;
        end
      end
      lfo_pkg::SHAPE_SQUARE: begin
        shp_mag_d = lfo_pkg::Q30_ONE;
        shp_neg_d = ph_frac[31];
      end
      lfo_pkg::SHAPE_STEP: begin
        shp_mag_d = lfo_pkg::step_mag(ph_frac[31:29]);
        shp_neg_d = lfo_pkg::step_neg(ph_frac[31:29]);
      end
      default: begin
        shp_mag_d = '0;
      end
    endcase
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_PH_MUL: begin
        mul_a = step_q;
        mul_b = lfo_pkg::MUL_W'(count_q);
      end
      ST_FD_MUL: begin
        mul_a = lfo_pkg::MUL_W'(rate_q);
        mul_b = lfo_pkg::MUL_W'(count_q);
      end
      ST_SQ: begin
        mul_a = {1'b0, m_q};
        mul_b = {1'b0, m_q};
      end
      ST_HORN_MUL: begin
        mul_a = p_q;
        mul_b = y_q;
      end
      ST_SIN_M: begin
        mul_a = p_q;
        mul_b = {1'b0, m_q};
      end
      ST_FADE_MUL: begin
        mul_a = mag_q;
        mul_b = lfo_pkg::MUL_W'(fade_eff);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_p_q <= mul_a * mul_b;
  end

  // Fade growth, saturating at one
  always_comb begin
    fade_sum_d = 26'(fade_q) + 26'(mul_p_q[24:0]);
    if ((mul_p_q[63:25] != '0) || (fade_sum_d > 26'(lfo_pkg::FADE_ONE))) begin
      fade_d = lfo_pkg::FADE_ONE;
    end else begin
      fade_d = fade_sum_d[24:0];
    end
  end

  // Round half up on the magnitude, clamp, apply sign
  always_comb begin
    rnd_d = (mul_p_q + RND_HALF) >> RND_SH;
    if (neg_q) begin
      lim_d   = (rnd_d > NEG_MAX) ? NEG_MAX : rnd_d;
      level_d = LEVEL_BITS'(0) - lim_d[LEVEL_BITS-1:0];
    end else begin
      lim_d   = (rnd_d > POS_MAX) ? POS_MAX : rnd_d;
      level_d = lim_d[LEVEL_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= '0;
      fade_q      <= '0;
      level_q     <= '0;
      out_level_q <= '0;
      out_valid_q <= 1'b0;
      shape_q     <= '0;
      step_q      <= '0;
      rate_q      <= '0;
      count_q     <= '0;
      m_q         <= '0;
      y_q         <= '0;
      p_q         <= '0;
      mag_q       <= '0;
      neg_q       <= 1'b0;
      k_q         <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          lfo_pkg::CFG_SHAPE: shape_q <= cfg_data_i[lfo_pkg::SHAPE_W-1:0];
          lfo_pkg::CFG_STEP:  step_q  <= cfg_data_i[lfo_pkg::STEP_W-1:0];
          lfo_pkg::CFG_RATE:  rate_q  <= cfg_data_i[lfo_pkg::RATE_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            count_q <= in_count;
            if (s_axis_tuser == lfo_pkg::REQ_RETRIG) begin
              phase_q <= PHASE_BITS'(in_start);
              fade_q  <= fade_on ? '0 : lfo_pkg::FADE_ONE;
              state_q <= ST_SHAPE;
            end else if (in_count == '0) begin
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_PH_MUL;
            end
          end
        end
        ST_PH_MUL: state_q <= ST_PH_ADD;
        ST_PH_ADD: begin
          phase_q <= phase_q + mul_p_q[PHASE_BITS-1:0];
          state_q <= (fade_on && (fade_q < lfo_pkg::FADE_ONE)) ? ST_FD_MUL : ST_SHAPE;
        end
        ST_FD_MUL: state_q <= ST_FD_ADD;
        ST_FD_ADD: begin
          fade_q  <= fade_d;
          state_q <= ST_SHAPE;
        end
        ST_SHAPE: begin
          m_q     <= fold_d;
          mag_q   <= shp_mag_d;
          neg_q   <= shp_neg_d;
          state_q <= (shape_q == lfo_pkg::SHAPE_SINE) ? ST_SQ : ST_FADE_MUL;
        end
        ST_SQ: state_q <= ST_SIN_Y;
        ST_SIN_Y: begin
          y_q     <= mul_p_q[61:30];
          p_q     <= lfo_pkg::SC11;
          k_q     <= '0;
          state_q <= ST_HORN_MUL;
        end
        ST_HORN_MUL: state_q <= ST_HORN_SUB;
        ST_HORN_SUB: begin
          p_q     <= lfo_pkg::sin_coef(k_q) - mul_p_q[61:30];
          k_q     <= k_q + 3'd1;
          state_q <= (k_q == lfo_pkg::HORNER_LAST) ? ST_SIN_M : ST_HORN_MUL;
        end
        ST_SIN_M: state_q <= ST_SIN_MAG;
        ST_SIN_MAG: begin
          mag_q   <= mul_p_q[61:30];
          state_q <= ST_FADE_MUL;
        end
        ST_FADE_MUL: state_q <= ST_ROUND;
        ST_ROUND: begin
          level_q <= level_d;
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) begin
            out_level_q <= level_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
